/* rtl/ascii_sensor_frame_decoder_unit_assert.svh */
// Assertion macros for the ASCII sensor frame decoder checker.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASCII_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`define ASCII_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("asfd checker: same-cycle property failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("asfd checker: next-cycle property failed");

`endif

/* rtl/asfd_pkg.sv */
// Shared constants and types of the ASCII sensor frame decoder.
// Used by the parser, the top level and the checker; depends on nothing.
package asfd_pkg;

  // Frame geometry: the window holds a packet minus its three trailer bytes.
  localparam int PACKET_SIZE = 24;
  localparam int WIN_LEN     = PACKET_SIZE - 3;
  localparam int WIN_AW      = $clog2(WIN_LEN);
  localparam int FILL_W      = $clog2(WIN_LEN + 1);

  // Field positions inside the window, oldest byte at offset zero.
  localparam int F1_LO = 3;
  localparam int F1_HI = 8;
  localparam int F2_LO = 14;
  localparam int F2_HI = 18;

  // Fixed point scaling and result widths.
  localparam int FRAC_DIGITS = 3;
  localparam int FRAC_W      = $clog2(FRAC_DIGITS + 2);
  localparam int FIRST_W     = 31;
  localparam int SECOND_W    = 28;

  // Magnitude accumulator: six digits plus up to three padding digits fit in 40 bits.
  localparam int MAG_W = 40;

  // Register codes, selected by paddr[2].
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  // Reset values of the marker registers.
  localparam logic [7:0] START_RESET = 8'h52;
  localparam logic [7:0] END_RESET   = 8'h25;

  // Commands from the sequencer to the field parser.
  typedef struct packed {
    logic       start;
    logic       valid;
    logic [7:0] data;
    logic       finish;
  } asfd_pcmd_t;

  // Status of the field parser.
  typedef struct packed {
    logic             done;
    logic             neg;
    logic             any;
    logic [MAG_W-1:0] mag;
  } asfd_pstat_t;

endpackage

/* rtl/ascii_sensor_frame_decoder_unit.sv */
// Top level of the ASCII sensor frame decoder: window RAM, sequencer, APB registers.
// Depends on asfd_pkg, asfd_ram and asfd_field_parser.
//
//   channel   direction  handshake               word
//   in        sink       in_valid_i / in_ready_o  rx_byte_i
//   out       source     out_valid_o/out_ready_i  first/second value and ok flags
//   cfg       APB slave  psel/penable/pready      start_marker, end_marker
//
// A byte that leaves the window short of full is taken in S_IDLE alone; a byte that
// fills or slides the window also passes S_CHECK, where the oldest byte is read back
// from the window RAM. A matched frame then reads its eleven field bytes through the
// RAM read port, and each field is scaled up once for every missing fraction digit.
// The result waits in the output register; a second frame stalls only if it is
// still there. Reset empties the window at once and restores both markers.
module ascii_sensor_frame_decoder_unit
  import asfd_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 rx_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [FIRST_W-1:0]  first_value_o,
  output logic                       first_ok_o,
  output logic signed [SECOND_W-1:0] second_value_o,
  output logic                       second_ok_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_F1    = 3'd2;
  localparam logic [2:0] S_FIN1  = 3'd3;
  localparam logic [2:0] S_F2    = 3'd4;
  localparam logic [2:0] S_FIN2  = 3'd5;

  localparam logic [MAG_W-1:0] FIRST_LIM  = MAG_W'(1) << (FIRST_W - 1);
  localparam logic [MAG_W-1:0] SECOND_LIM = MAG_W'(1) << (SECOND_W - 1);

  logic [2:0]        state_q, state_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [WIN_AW-1:0] head_q, head_d;
  logic [WIN_AW-1:0] iss_off_q, iss_off_d;
  logic              rd_pend_q, rd_pend_d;
  logic [7:0]        byte_q, byte_d;
  logic [7:0]        start_q, end_q;
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic              f1_load;

  logic [FIRST_W-1:0]  f1_val_q, f1_val_d;
  logic                f1_ok_q;
  logic [FIRST_W-1:0]  first_val_q;
  logic                first_ok_q;
  logic [SECOND_W-1:0] second_val_q, second_val_d;
  logic                second_ok_q;

  logic [MAG_W-1:0]  f1_fix;
  logic [MAG_W-1:0]  f2_fix;

  logic              ram_we;
  logic [WIN_AW-1:0] ram_waddr;
  logic [WIN_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  asfd_pcmd_t  pcmd;
  asfd_pstat_t pstat;

  // Window position of an offset from the oldest byte, wrapping at the window length.
  function automatic logic [WIN_AW-1:0] win_addr(input logic [WIN_AW-1:0] base,
                                                 input logic [WIN_AW-1:0] off);
    logic [WIN_AW:0] sum;
    begin
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (WIN_AW + 1)'(WIN_LEN)) begin
        sum = sum - (WIN_AW + 1)'(WIN_LEN);
      end
      return sum[WIN_AW-1:0];
    end
  endfunction

  // Signed result with saturation to the field range given by lim.
  function automatic logic [MAG_W-1:0] fix_value(input logic             neg,
                                                 input logic [MAG_W-1:0] mag,
                                                 input logic [MAG_W-1:0] lim);
    logic [MAG_W-1:0] m;
    begin
      if (neg) begin
        m = (mag > lim) ? lim : mag;
        return ~m + 1'b1;
      end else begin
        m = (mag > lim - 1'b1) ? (lim - 1'b1) : mag;
        return m;
      end
    end
  endfunction

  // Window storage, kept as a ring with head_q at the oldest byte.
  asfd_ram #(
    .WIDTH(8),
    .DEPTH(WIN_LEN)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (rx_byte_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared field parser, run once per field.
  asfd_field_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pcmd),
    .stat_o (pstat)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // Parsed values in output form.
  assign f1_fix       = fix_value(pstat.neg, pstat.mag, FIRST_LIM);
  assign f2_fix       = fix_value(pstat.neg, pstat.mag, SECOND_LIM);
  assign f1_val_d     = pstat.any ? f1_fix[FIRST_W-1:0] : '0;
  assign second_val_d = pstat.any ? f2_fix[SECOND_W-1:0] : '0;

  // Sequencer: window update, frame check and field reads.
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    head_d      = head_q;
    iss_off_d   = iss_off_q;
    rd_pend_d   = 1'b0;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    f1_load     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_raddr   = head_q;
    pcmd        = '0;
    pcmd.data   = ram_rdata;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ram_we = 1'b1;
          byte_d = rx_byte_i;
          if (fill_q < FILL_W'(WIN_LEN)) begin
            ram_waddr = win_addr(head_q, fill_q[WIN_AW-1:0]);
            fill_d    = fill_q + 1'b1;
            ram_raddr = head_q;
            if (fill_q == FILL_W'(WIN_LEN - 1)) begin
              state_d = S_CHECK;
            end
          end else begin
            // Full window: overwrite the oldest byte and advance the head.
            ram_waddr = head_q;
            head_d    = win_addr(head_q, WIN_AW'(1));
            ram_raddr = win_addr(head_q, WIN_AW'(1));
            state_d   = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (ram_rdata == start_q && byte_q == end_q) begin
          fill_d     = '0;
          pcmd.start = 1'b1;
          ram_raddr  = win_addr(head_q, WIN_AW'(F1_LO));
          iss_off_d  = WIN_AW'(F1_LO + 1);
          rd_pend_d  = 1'b1;
          state_d    = S_F1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_F1: begin
        pcmd.valid = rd_pend_q;
        if (iss_off_q <= WIN_AW'(F1_HI)) begin
          ram_raddr = win_addr(head_q, iss_off_q);
          iss_off_d = iss_off_q + 1'b1;
          rd_pend_d = 1'b1;
        end else begin
          state_d = S_FIN1;
        end
      end
      S_FIN1: begin
        pcmd.finish = 1'b1;
        if (pstat.done) begin
          f1_load    = 1'b1;
          pcmd.start = 1'b1;
          ram_raddr  = win_addr(head_q, WIN_AW'(F2_LO));
          iss_off_d  = WIN_AW'(F2_LO + 1);
          rd_pend_d  = 1'b1;
          state_d    = S_F2;
        end
      end
      S_F2: begin
        pcmd.valid = rd_pend_q;
        if (iss_off_q <= WIN_AW'(F2_HI)) begin
          ram_raddr = win_addr(head_q, iss_off_q);
          iss_off_d = iss_off_q + 1'b1;
          rd_pend_d = 1'b1;
        end else begin
          state_d = S_FIN2;
        end
      end
      S_FIN2: begin
        pcmd.finish = 1'b1;
        if (pstat.done && (!out_valid_q || out_ready_i)) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and markers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      head_q      <= '0;
      iss_off_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
      start_q     <= START_RESET;
      end_q       <= END_RESET;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_q      <= head_d;
      iss_off_q   <= iss_off_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          REG_START: start_q <= pwdata[7:0];
          REG_END:   end_q   <= pwdata[7:0];
          default:   start_q <= start_q;
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    if (f1_load) begin
      f1_val_q <= f1_val_d;
      f1_ok_q  <= pstat.any;
    end
    if (out_load) begin
      first_val_q  <= f1_val_q;
      first_ok_q   <= f1_ok_q;
      second_val_q <= second_val_d;
      second_ok_q  <= pstat.any;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_START: prdata = 32'(start_q);
      REG_END:   prdata = 32'(end_q);
      default:   prdata = '0;
    endcase
  end

  assign pready         = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign first_value_o  = $signed(first_val_q);
  assign first_ok_o     = first_ok_q;
  assign second_value_o = $signed(second_val_q);
  assign second_ok_o    = second_ok_q;

endmodule

/* rtl/asfd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Self-contained; sized by its WIDTH and DEPTH parameters.
module asfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 21
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/asfd_field_parser.sv */
// Character-at-a-time ASCII decimal parser for one field.
// Depends on asfd_pkg for the command and status structs and the scaling.
module asfd_field_parser
  import asfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  asfd_pcmd_t  cmd_i,
  output asfd_pstat_t stat_o
);

  // Parse phases.
  localparam logic [1:0] PH_LEAD = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  logic [1:0]        phase_q, phase_d;
  logic              neg_q, neg_d;
  logic              any_q, any_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [MAG_W-1:0]  mag_q, mag_d;

  logic [7:0]       c;
  logic             is_blank;
  logic             is_digit;
  logic             frac_room;
  logic [MAG_W-1:0] mag_x10;

  assign c         = cmd_i.data;
  assign is_blank  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  assign is_digit  = (c >= 8'h30) && (c <= 8'h39);
  assign frac_room = (frac_q < FRAC_W'(FRAC_DIGITS));
  assign mag_x10   = (mag_q << 3) + (mag_q << 1);

  // One character step, or one padding step once the field has ended.
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    any_d   = any_q;
    frac_d  = frac_q;
    mag_d   = mag_q;
    if (cmd_i.start) begin
      phase_d = PH_LEAD;
      neg_d   = 1'b0;
      any_d   = 1'b0;
      frac_d  = '0;
      mag_d   = '0;
    end else if (cmd_i.valid) begin
      unique case (phase_q)
        PH_LEAD: begin
          if (is_blank) begin
            phase_d = PH_LEAD;
          end else if (c == 8'h2b || c == 8'h2d) begin
            neg_d   = (c == 8'h2d);
            phase_d = PH_INT;
          end else if (is_digit) begin
            mag_d   = mag_x10 + MAG_W'(c[3:0]);
            any_d   = 1'b1;
            phase_d = PH_INT;
          end else if (c == 8'h2e) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            mag_d = mag_x10 + MAG_W'(c[3:0]);
            any_d = 1'b1;
          end else if (c == 8'h2e) begin
            phase_d = PH_FRAC;
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_FRAC: begin
          if (is_digit) begin
            any_d = 1'b1;
            if (frac_room) begin
              mag_d  = mag_x10 + MAG_W'(c[3:0]);
              frac_d = frac_q + 1'b1;
            end
          end else begin
            phase_d = PH_STOP;
          end
        end
        PH_STOP: begin
          phase_d = PH_STOP;
        end
        default: begin
          phase_d = PH_STOP;
        end
      endcase
    end else if (cmd_i.finish && frac_room) begin
      // Scale up for every fraction digit that was not given.
      mag_d  = mag_x10;
      frac_d = frac_q + 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      frac_q  <= '0;
    end else begin
      phase_q <= phase_d;
      frac_q  <= frac_d;
    end
  end

  // Accumulated value.
  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    any_q <= any_d;
    mag_q <= mag_d;
  end

  assign stat_o.done = !frac_room;
  assign stat_o.neg  = neg_q;
  assign stat_o.any  = any_q;
  assign stat_o.mag  = mag_q;

endmodule

/* rtl/asfd_checker.sv */
// Port-level checker for the ASCII sensor frame decoder, bound to the top level.
// Depends on asfd_pkg and the assertion macros header.
`include "ascii_sensor_frame_decoder_unit_assert.svh"

module asfd_checker
  import asfd_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic signed [FIRST_W-1:0]  first_value_o,
  input logic                       first_ok_o,
  input logic signed [SECOND_W-1:0] second_value_o,
  input logic                       second_ok_o
);

  logic [FIRST_W+SECOND_W+1:0] out_word;
  logic                        first_zero_ok;
  logic                        second_zero_ok;

  // The whole result word, and the zero-value rule of each field.
  assign out_word       = {first_value_o, first_ok_o, second_value_o, second_ok_o};
  assign first_zero_ok  = first_ok_o || (first_value_o == '0);
  assign second_zero_ok = second_ok_o || (second_value_o == '0);

  // A stalled result word stays offered and unchanged.
  `ASFD_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `ASFD_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_word))

  // A result only appears after the field reads, never right after a byte is taken.
  `ASFD_ASSERT_NOW(a_out_not_after_byte, $rose(out_valid_o), !$past(in_valid_i && in_ready_o))

  // A field without digits reports a zero value.
  `ASFD_ASSERT_NOW(a_empty_is_zero, out_valid_o, first_zero_ok && second_zero_ok)

endmodule

bind ascii_sensor_frame_decoder_unit asfd_checker u_asfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .first_value_o  (first_value_o),
  .first_ok_o     (first_ok_o),
  .second_value_o (second_value_o),
  .second_ok_o    (second_ok_o)
);

/* verif/ascii_sensor_frame_decoder_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ASCII sensor frame decoder top level.
// Depends on asfd_pkg and ascii_sensor_frame_decoder_unit; a scoreboard class predicts readings.

module ascii_sensor_frame_decoder_unit_tb
  import asfd_pkg::*;
();

  localparam int         F1_LEN        = F1_HI - F1_LO + 1;
  localparam int         F2_LEN        = F2_HI - F2_LO + 1;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         QUIET_LIMIT   = 2000;
  localparam logic [2:0] START_ADDR    = {REG_START, 2'b00};
  localparam logic [2:0] END_ADDR      = {REG_END, 2'b00};
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_VT         = 8'h0B;
  localparam logic [7:0] CH_FF         = 8'h0C;
  localparam logic [7:0] CH_CR         = 8'h0D;

  // One decoded reading, as it leaves the output channel.
  typedef struct packed {
    logic signed [FIRST_W-1:0]  first_value;
    logic                       first_ok;
    logic signed [SECOND_W-1:0] second_value;
    logic                       second_ok;
  } reading_t;

  // Tracks the byte window and markers, and holds the readings still owed by the block.
  class reading_tracker;
    logic [7:0] window [WIN_LEN];
    int         fill;
    logic [7:0] start_mk;
    logic [7:0] end_mk;
    reading_t   pending_readings [$];
    int         predicted;
    int         mismatches;

    function new();
      fill       = 0;
      start_mk   = START_RESET;
      end_mk     = END_RESET;
      predicted  = 0;
      mismatches = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    // Reads one ASCII field of the window as a number scaled by 10^FRAC_DIGITS.
    function longint parse_field(input int lo, input int hi, input int width,
                                 output logic ok);
      int              pos;
      bit              neg;
      bit              seen_digit;
      longint unsigned mag;
      longint unsigned lim;
      int              frac_cnt;
      pos        = lo;
      neg        = 1'b0;
      seen_digit = 1'b0;
      mag        = 0;
      frac_cnt   = 0;
      lim        = 64'd1 << (width - 1);
      while (pos <= hi && is_blank(window[pos])) pos++;
      if (pos <= hi && (window[pos] == "+" || window[pos] == "-")) begin
        neg = (window[pos] == "-");
        pos++;
      end
      while (pos <= hi && is_digit(window[pos])) begin
        mag        = mag * 10 + (window[pos] - "0");
        seen_digit = 1'b1;
        pos++;
      end
      if (pos <= hi && window[pos] == ".") begin
        pos++;
        // Fraction digits past the scale are dropped, not rounded.
        while (pos <= hi && is_digit(window[pos])) begin
          if (frac_cnt < FRAC_DIGITS) begin
            mag = mag * 10 + (window[pos] - "0");
            frac_cnt++;
          end
          seen_digit = 1'b1;
          pos++;
        end
      end
      while (frac_cnt < FRAC_DIGITS) begin
        mag = mag * 10;
        frac_cnt++;
      end
      ok = seen_digit;
      if (!seen_digit) return 0;
      // Saturate to the signed range of the output field.
      if (neg) begin
        if (mag > lim) mag = lim;
        return -longint'(mag);
      end
      if (mag > lim - 1) mag = lim - 1;
      return longint'(mag);
    endfunction

    // Slides one accepted byte into the window and predicts a reading on a frame match.
    function void note_byte(logic [7:0] b);
      reading_t r;
      logic     ok;
      if (fill < WIN_LEN) begin
        window[fill] = b;
        fill++;
      end else begin
        for (int k = 0; k < WIN_LEN - 1; k++) window[k] = window[k + 1];
        window[WIN_LEN - 1] = b;
      end
      if (fill == WIN_LEN && window[0] == start_mk && window[WIN_LEN - 1] == end_mk) begin
        r.first_value  = FIRST_W'(parse_field(F1_LO, F1_HI, FIRST_W, ok));
        r.first_ok     = ok;
        r.second_value = SECOND_W'(parse_field(F2_LO, F2_HI, SECOND_W, ok));
        r.second_ok    = ok;
        pending_readings.push_back(r);
        predicted++;
        fill = 0;
      end
    endfunction

    task report_mismatch(input string msg);
      $display("%0t: reading mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Compares a reading from the block with the oldest one owed.
    task check_reading(input reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        report_mismatch("reading arrived with no frame pending");
        return;
      end
      want = pending_readings.pop_front();
      if (got.first_value !== want.first_value)
        report_mismatch($sformatf("first_value %0d, expected %0d",
                                  $signed(got.first_value), $signed(want.first_value)));
      if (got.first_ok !== want.first_ok)
        report_mismatch($sformatf("first_ok %b, expected %b", got.first_ok, want.first_ok));
      if (got.second_value !== want.second_value)
        report_mismatch($sformatf("second_value %0d, expected %0d",
                                  $signed(got.second_value), $signed(want.second_value)));
      if (got.second_ok !== want.second_ok)
        report_mismatch($sformatf("second_ok %b, expected %b", got.second_ok, want.second_ok));
    endtask
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [7:0]                 rx_byte_i;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [FIRST_W-1:0]  first_value_o;
  logic                       first_ok_o;
  logic signed [SECOND_W-1:0] second_value_o;
  logic                       second_ok_o;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  reading_tracker sb;
  int             send_idle_pct;
  int             stall_pct;
  int             bytes_sent;
  int             settings_used;
  int             quiet_cycles = 0;

  ascii_sensor_frame_decoder_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .first_value_o  (first_value_o),
    .first_ok_o     (first_ok_o),
    .second_value_o (second_value_o),
    .second_ok_o    (second_ok_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #5 clk_i = ~clk_i;

  // Receiver side: random back-pressure at the current stall rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Every reading taken by the receiver goes to the scoreboard.
  always @(posedge clk_i) begin : reading_monitor
    reading_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.first_value  = first_value_o;
      got.first_ok     = first_ok_o;
      got.second_value = second_value_o;
      got.second_ok    = second_ok_o;
      sb.check_reading(got);
    end
  end

  // Ends the run when neither channel has moved a word for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("ascii_sensor_frame_decoder_unit_tb: FAIL");
      $finish;
    end
  end

  // Offers one byte, after a random idle gap, and holds it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // Stops sending until every owed reading is out and the block has settled.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write with a setup phase and an access phase; the upper data bits carry noise.
  task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [7:0] start_value, input logic [7:0] end_value);
    wait_drained();
    apb_write(START_ADDR, start_value);
    sb.start_mk = start_value;
    apb_write(END_ADDR, end_value);
    sb.end_mk = end_value;
    settings_used++;
  endtask

  // Builds a full window: start marker, the two fields, random filler, end byte.
  task automatic send_frame(input logic [8*F1_LEN-1:0] f1, input logic [8*F2_LEN-1:0] f2,
                            input bit good_end);
    logic [7:0] frame_bytes [WIN_LEN];
    for (int k = 0; k < WIN_LEN; k++) frame_bytes[k] = 8'($urandom);
    frame_bytes[0] = sb.start_mk;
    for (int k = 0; k < F1_LEN; k++) frame_bytes[F1_LO + k] = f1[8*(F1_LEN-k)-1 -: 8];
    for (int k = 0; k < F2_LEN; k++) frame_bytes[F2_LO + k] = f2[8*(F2_LEN-k)-1 -: 8];
    frame_bytes[WIN_LEN - 1] = good_end ? sb.end_mk
                                        : sb.end_mk ^ (8'd1 << $urandom_range(0, 7));
    for (int k = 0; k < WIN_LEN; k++) send_byte(frame_bytes[k]);
  endtask

  function automatic logic [7:0] blank_char();
    if ($urandom_range(0, 5) == 0) return " ";
    return 8'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // A field character biased toward the characters the parser cares about.
  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return "0" + 8'($urandom_range(0, 9));
      4: return blank_char();
      5: return $urandom_range(0, 1) ? "+" : "-";
      6: return ".";
      7: begin
        case ($urandom_range(0, 2))
          0: return "e";
          1: return "E";
          default: return "x";
        endcase
      end
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed numbers of random shape; the rest is loose characters.
  function automatic logic [8*F1_LEN-1:0] random_field(input int len);
    logic [7:0]          chars [F1_LEN];
    logic [8*F1_LEN-1:0] text;
    int                  pos;
    int                  n;
    for (int k = 0; k < F1_LEN; k++) chars[k] = field_char();
    pos = 0;
    if ($urandom_range(0, 9) < 7) begin
      n = $urandom_range(0, 2);
      for (int k = 0; k < n; k++) begin
        chars[pos] = blank_char();
        pos++;
      end
      if ($urandom_range(0, 1)) begin
        chars[pos] = $urandom_range(0, 1) ? "+" : "-";
        pos++;
      end
      n = $urandom_range(0, len - pos);
      for (int k = 0; k < n; k++) begin
        chars[pos] = "0" + 8'($urandom_range(0, 9));
        pos++;
      end
      if (pos < len && $urandom_range(0, 1)) begin
        chars[pos] = ".";
        pos++;
        n = $urandom_range(0, len - pos);
        for (int k = 0; k < n; k++) begin
          chars[pos] = "0" + 8'($urandom_range(0, 9));
          pos++;
        end
      end
    end
    text = '0;
    for (int k = 0; k < len; k++) text = (text << 8) | chars[k];
    return text;
  endfunction

  // Hand-picked frames: value extremes, parser corner cases, sliding and resync.
  task automatic run_directed();
    // A few loose bytes first, so the window fills and then slides.
    repeat (7) send_byte(8'($urandom));
    send_frame("999999", "99999", 1'b1);
    send_frame("-99999", "-9999", 1'b1);
    send_frame("000000", "00000", 1'b1);
    send_frame("  12.5", "-0.00", 1'b1);
    send_frame("1.2345", ".1234", 1'b1);
    send_frame("      ", "     ", 1'b1);
    send_frame("-     ", "+    ", 1'b1);
    send_frame(".     ", "  .  ", 1'b1);
    send_frame("inf   ", "nan  ", 1'b1);
    send_frame("1e3   ", "0x5  ", 1'b1);
    send_frame({CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, "7"}, {" ", CH_TAB, "-42"}, 1'b1);
    send_frame("- 5   ", "5 5  ", 1'b1);
    send_frame("12-3  ", "+-1  ", 1'b1);
    send_frame("7.    ", "3.   ", 1'b1);
    send_frame("-0    ", "00.9 ", 1'b1);
    send_frame({8'hFF, "12", 8'h80, "34"}, {8'h00, "5.5", 8'h7F}, 1'b1);
    // A frame with a wrong last byte must slide on and resync on the next one.
    send_frame("123456", "12345", 1'b0);
    send_frame("+31415", "-2.71", 1'b1);
  endtask

  // Random traffic: good frames, broken frames and loose bytes, with pauses.
  task automatic run_random(input int min_bytes, input int min_frames);
    int first_byte;
    int first_frame;
    int pick;
    first_byte  = bytes_sent;
    first_frame = sb.predicted;
    while (bytes_sent - first_byte < min_bytes || sb.predicted - first_frame < min_frames) begin
      pick = $urandom_range(0, 19);
      if (pick < 15) send_frame(random_field(F1_LEN), (8*F2_LEN)'(random_field(F2_LEN)), 1'b1);
      else if (pick < 17)
        send_frame(random_field(F1_LEN), (8*F2_LEN)'(random_field(F2_LEN)), 1'b0);
      else repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
      if ($urandom_range(0, 11) == 0) wait_drained();
    end
  endtask

  // Reset, directed frames, then four phases of random traffic and marker settings.
  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    bytes_sent    = 0;
    settings_used = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    run_random(160, 6);

    set_markers(8'h00, 8'hFF);
    send_idle_pct = 74;
    run_random(160, 6);

    set_markers(8'hFF, 8'h00);
    send_idle_pct = 0;
    stall_pct     = 74;
    run_random(160, 6);

    set_markers(8'($urandom), 8'($urandom));
    send_idle_pct = 16;
    stall_pct     = 16;
    run_random(160, 6);

    wait_drained();
    $display("Sent %0d bytes, %0d frames decoded, under %0d marker settings.",
             bytes_sent, sb.predicted, settings_used);
    $display("Idle and stall rates of 0, 16 and 74 percent; %0d field mismatches.",
             sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("ascii_sensor_frame_decoder_unit_tb: PASS");
    end else begin
      $display("ascii_sensor_frame_decoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
